/* src/fsms_pkg.sv */
// shared types and constants for the framed sensor moving-sum block
package fsms_pkg;

    localparam logic [7:0] HEADER_FIRST = 8'hAA;
    localparam logic [7:0] HEADER_SECOND = 8'h55;

    localparam logic [4:0] POS_HEAD2 = 5'd1;
    localparam logic [4:0] POS_BODY_START = 5'd2;
    localparam logic [4:0] POS_SAMPLE_FIRST = 5'd8;
    localparam logic [4:0] POS_SAMPLE_LAST = 5'd23;
    localparam logic [4:0] POS_XOR = 5'd25;
    localparam logic [4:0] POS_SUM = 5'd26;

    localparam int SAMPLE_BYTES = 16;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W = 23;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_NO_HEADER = 3'd1,
        ST_SHORT = 3'd2,
        ST_XOR_ERR = 3'd3,
        ST_SUM_ERR = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEAD2,
        PH_BODY,
        PH_CHECK
    } parse_phase_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_STATUS,
        EM_READ,
        EM_UPDATE
    } emit_state_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       timeout_flag;
    } fsms_in_t;

    typedef struct packed {
        logic [2:0]          channel;
        logic [SAMPLE_W-1:0] latest_sample;
        logic [SUM_W-1:0]    window_sum;
        logic [2:0]          status;
        logic                last;
    } fsms_out_t;

    typedef struct packed {
        logic    valid;
        logic    frame;
        status_t status;
    } fsms_evt_t;

endpackage

/* src/fsms_parser.sv */
// frame parser: header hunt, xor and sum checks, sample byte capture
module fsms_parser
    import fsms_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  fsms_in_t                    in_item,
    output fsms_evt_t                   evt,
    output logic [SAMPLE_BYTES*8-1:0]   samples
);

    parse_phase_t phase_reg, phase_next;
    logic [4:0] pos_reg, pos_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] samples_reg [SAMPLE_BYTES];
    logic       shift_en;
    logic [7:0] rx;
    logic [7:0] byte_sum;
    logic [4:0] pos_inc;

    assign rx = in_item.rx_byte;
    assign byte_sum = sum_reg + rx;
    assign pos_inc = pos_reg + 5'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg <= '0;
            xor_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            xor_reg <= xor_next;
            sum_reg <= sum_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        xor_next = xor_reg;
        sum_next = sum_reg;
        shift_en = 1'b0;
        evt = '{valid: 1'b0, frame: 1'b0, status: ST_OK};
        if (accept)
        begin
            if (in_item.timeout_flag)
            begin
                evt.valid = 1'b1;
                unique case (phase_reg) inside
                    PH_HUNT, PH_HEAD2: evt.status = ST_NO_HEADER;
                    PH_BODY:           evt.status = ST_SHORT;
                    default:           evt.status = (pos_reg == POS_XOR) ? ST_XOR_ERR
                                                                         : ST_SUM_ERR;
                endcase
                phase_next = PH_HUNT;
                pos_next = '0;
                xor_next = '0;
                sum_next = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (rx == HEADER_FIRST)
                        begin
                            phase_next = PH_HEAD2;
                            pos_next = POS_HEAD2;
                            xor_next = HEADER_FIRST;
                            sum_next = HEADER_FIRST;
                        end
                    end
                    PH_HEAD2:
                    begin
                        if (rx == HEADER_SECOND)
                        begin
                            phase_next = PH_BODY;
                            pos_next = POS_BODY_START;
                            xor_next = xor_reg ^ rx;
                            sum_next = byte_sum;
                        end
                        else if (rx != HEADER_FIRST)
                        begin
                            phase_next = PH_HUNT;
                            pos_next = '0;
                            xor_next = '0;
                            sum_next = '0;
                        end
                    end
                    PH_BODY:
                    begin
                        shift_en = (pos_reg >= POS_SAMPLE_FIRST) && (pos_reg <= POS_SAMPLE_LAST);
                        xor_next = xor_reg ^ rx;
                        sum_next = byte_sum;
                        pos_next = pos_inc;
                        if (pos_inc >= POS_XOR)
                        begin
                            pos_next = POS_XOR;
                            phase_next = PH_CHECK;
                        end
                    end
                    default:
                    begin
                        if (pos_reg == POS_XOR)
                        begin
                            if (rx != xor_reg)
                            begin
                                evt.valid = 1'b1;
                                evt.status = ST_XOR_ERR;
                                phase_next = PH_HUNT;
                                pos_next = '0;
                                xor_next = '0;
                                sum_next = '0;
                            end
                            else
                            begin
                                sum_next = byte_sum;
                                pos_next = POS_SUM;
                            end
                        end
                        else
                        begin
                            evt.valid = 1'b1;
                            evt.frame = (byte_sum == 8'd0);
                            evt.status = (byte_sum == 8'd0) ? ST_OK : ST_SUM_ERR;
                            phase_next = PH_HUNT;
                            pos_next = '0;
                            xor_next = '0;
                            sum_next = '0;
                        end
                    end
                endcase
            end
        end
    end

    // shift line: after a full frame, entry i holds frame byte 8 + i
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < SAMPLE_BYTES - 1; i++)
            begin
                samples_reg[i] <= samples_reg[i+1];
            end
            samples_reg[SAMPLE_BYTES-1] <= rx;
        end
    end

    for (genvar g = 0; g < SAMPLE_BYTES; g++)
    begin : g_samples
        assign samples[8*g +: 8] = samples_reg[g];
    end

endmodule

/* src/fsms_window.sv */
// history memory, per-channel window sums and result sequencer
module fsms_window
    import fsms_pkg::*;
#(
    parameter int HISTORY_DEPTH = 128,
    parameter int CHANNELS = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  fsms_evt_t                 evt,
    input  logic [SAMPLE_BYTES*8-1:0] samples,
    input  logic [7:0]                window_length,
    output logic                      busy,
    output logic                      out_valid,
    input  logic                      out_stall,
    output fsms_out_t                 out_data
);

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEM_DEPTH = HISTORY_DEPTH * CHANNELS;
    localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CMP_W = (SLOT_W + 1 > 9) ? SLOT_W + 1 : 9;

    emit_state_t state_reg, state_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    status_t           code_reg, code_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W:0]   fill_reg, fill_next;
    logic [SUM_W-1:0]  sums_reg [CHANNELS];
    logic              out_valid_reg, out_valid_next;
    fsms_out_t         out_reg, out_next;

    logic [SAMPLE_W-1:0] hist_mem [MEM_DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;
    logic [ADDR_W-1:0]   addr;
    logic                mem_re;
    logic                mem_we;
    logic                sum_we;
    logic                out_free;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]    new_sum;
    logic [CMP_W-1:0]    wl_ext;
    logic [CMP_W-1:0]    eff_len;
    logic [CMP_W-1:0]    slot_inc;
    logic [SLOT_W-1:0]   slot_adv;

    assign out_free = !out_valid_reg || !out_stall;
    assign addr = ADDR_W'(slot_reg) * ADDR_W'(CHANNELS) + ADDR_W'(ch_reg);
    assign sample = samples[SAMPLE_W*ch_reg +: SAMPLE_W];
    // slots at or past the fill mark were never written and still read as zero
    assign old_sample = ({1'b0, slot_reg} < fill_reg) ? rdata_reg : '0;
    assign new_sum = sums_reg[ch_reg] - SUM_W'(old_sample) + SUM_W'(sample);

    assign wl_ext = CMP_W'(window_length);
    assign eff_len = (wl_ext == '0) ? CMP_W'(1)
                   : (wl_ext > CMP_W'(HISTORY_DEPTH)) ? CMP_W'(HISTORY_DEPTH) : wl_ext;
    assign slot_inc = CMP_W'(slot_reg) + CMP_W'(1);
    assign slot_adv = (slot_inc >= eff_len) ? '0 : SLOT_W'(slot_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EM_IDLE;
            ch_reg <= '0;
            code_reg <= ST_OK;
            slot_reg <= '0;
            fill_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ch_reg <= ch_next;
            code_reg <= code_next;
            slot_reg <= slot_next;
            fill_reg <= fill_next;
            out_valid_reg <= out_valid_next;
            if (sum_we)
            begin
                sums_reg[ch_reg] <= new_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[addr] <= sample;
        end
        if (mem_re)
        begin
            rdata_reg <= hist_mem[addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ch_next = ch_reg;
        code_next = code_reg;
        slot_next = slot_reg;
        fill_next = fill_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_re = 1'b0;
        mem_we = 1'b0;
        sum_we = 1'b0;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (evt.valid)
                begin
                    code_next = evt.status;
                    ch_next = '0;
                    state_next = evt.frame ? EM_READ : EM_STATUS;
                end
            end
            EM_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = '{channel: 3'd0, latest_sample: '0, window_sum: '0,
                                 status: code_reg, last: 1'b1};
                    state_next = EM_IDLE;
                end
            end
            EM_READ:
            begin
                mem_re = 1'b1;
                state_next = EM_UPDATE;
            end
            default:
            begin
                if (out_free)
                begin
                    mem_we = 1'b1;
                    sum_we = 1'b1;
                    out_valid_next = 1'b1;
                    out_next = '{channel: 3'(ch_reg), latest_sample: sample,
                                 window_sum: new_sum, status: ST_OK,
                                 last: (ch_reg == CH_W'(CHANNELS - 1))};
                    if (ch_reg == CH_W'(CHANNELS - 1))
                    begin
                        slot_next = slot_adv;
                        if ({1'b0, slot_reg} == fill_reg)
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                        state_next = EM_IDLE;
                    end
                    else
                    begin
                        ch_next = ch_reg + 1'b1;
                        state_next = EM_READ;
                    end
                end
            end
        endcase
    end

    assign busy = (state_reg != EM_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule

/* src/framed_sensor_moving_sum.sv */
// top level of the framed sensor moving-sum block
// Byte-stream frame receiver with per-channel moving sums. Each transaction on
// the input carries one received byte and a timeout flag; bytes that do not end
// a frame are taken one per cycle with no stall. A bad check byte or a timeout
// gives one status result and holds the input during the status state. A good
// frame's final check byte holds the input while the sequencer, per channel,
// reads the history memory in its read state and does the read-modify-write of
// that slot and the channel's window sum in its update state. Results leave
// through an output register, so bytes keep flowing while a result waits; a
// status or channel result that finds the output register still stalled waits
// for it, and the input hold grows by those stall cycles. The history memory
// needs no clearing pass: a fill mark tracks written slots, and unwritten slots
// count as zero. The user must write window_length through the configuration
// port only while the block is idle; the block itself does not enforce this.
// Zero acts as one slot and values above HISTORY_DEPTH act as HISTORY_DEPTH.
module framed_sensor_moving_sum
    import fsms_pkg::*;
#(
    parameter int HISTORY_DEPTH = 128,
    parameter int CHANNELS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  fsms_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output fsms_out_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [7:0] cfg_data
);

    logic [7:0] window_length_reg;
    logic       busy;
    logic       accept;
    fsms_evt_t  evt;
    logic [SAMPLE_BYTES*8-1:0] samples;

    assign cfg_ready = 1'b1;
    assign in_stall = busy;
    assign accept = in_valid && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= 8'd100;
        end
        else if (cfg_valid && cfg_ready)
        begin
            window_length_reg <= cfg_data;
        end
    end

    fsms_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_item (in_data),
        .evt     (evt),
        .samples (samples)
    );

    fsms_window #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .CHANNELS      (CHANNELS)
    ) u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .evt           (evt),
        .samples       (samples),
        .window_length (window_length_reg),
        .busy          (busy),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data)
    );

endmodule

/* sim/testbench.sv */
// self-checking testbench for framed_sensor_moving_sum with random framed byte traffic
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fsms_pkg::*;

    localparam int HISTORY_DEPTH = 128;
    localparam int CHANNELS = 8;
    localparam int FRAME_BYTES = 27;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 4 * CHANNELS + 8;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES = 6;

    typedef enum int {
        SEQ_GOOD,
        SEQ_BAD_XOR,
        SEQ_BAD_SUM,
        SEQ_TIMEOUT_ANY,
        SEQ_TIMEOUT_XOR,
        SEQ_TIMEOUT_SUM,
        SEQ_NOISE,
        SEQ_RANDOM
    } seq_kind_t;

    localparam int PHASE_WINDOW [PHASES] = '{100, 1, 128, 0, 255, 3};
    localparam int PHASE_SEND_IDLE [PHASES] = '{0, 85, 0, 12, 0, 12};
    localparam int PHASE_RECV_STALL [PHASES] = '{0, 0, 85, 12, 0, 12};
    localparam int PHASE_ITEMS [PHASES] = '{35, 30, 30, 30, 30, 30};
    localparam seq_kind_t PHASE_FIRST_KIND [PHASES] =
        '{SEQ_GOOD, SEQ_BAD_XOR, SEQ_BAD_SUM, SEQ_TIMEOUT_XOR, SEQ_TIMEOUT_SUM, SEQ_GOOD};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    fsms_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    fsms_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_data = '0;

    fsms_in_t pending_items [$];
    fsms_out_t expected_results [$];
    fsms_out_t want;

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int holdoff_left = 0;
    logic holdoff_arm = 1'b0;
    logic holdoff_used = 1'b0;

    // parser model state
    parse_phase_t rx_phase = PH_HUNT;
    logic [4:0] rx_pos = '0;
    logic [7:0] rx_xor = '0;
    logic [7:0] rx_sum = '0;
    logic [7:0] rx_samples [SAMPLE_BYTES];
    logic [SAMPLE_W-1:0] history [HISTORY_DEPTH][CHANNELS];
    logic [SUM_W-1:0] win_sums [CHANNELS];
    int write_slot = 0;
    logic [7:0] window_cfg = 8'd100;

    framed_sensor_moving_sum #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .CHANNELS(CHANNELS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void parse_byte(fsms_in_t item);
        fsms_out_t res;
        logic emit_status;
        status_t code;
        logic [7:0] b;
        logic [7:0] total;
        logic [SAMPLE_W-1:0] sample;
        int span;
        int k;
        emit_status = 1'b0;
        code = ST_OK;
        b = item.rx_byte;
        if (item.timeout_flag)
        begin
            emit_status = 1'b1;
            case (rx_phase) inside
                PH_HUNT, PH_HEAD2: code = ST_NO_HEADER;
                PH_BODY: code = ST_SHORT;
                default: code = (rx_pos == POS_XOR) ? ST_XOR_ERR : ST_SUM_ERR;
            endcase
        end
        else
        begin
            case (rx_phase)
                PH_HUNT:
                begin
                    if (b == HEADER_FIRST)
                    begin
                        rx_phase = PH_HEAD2;
                        rx_pos = POS_HEAD2;
                        rx_xor = b;
                        rx_sum = b;
                    end
                end
                PH_HEAD2:
                begin
                    if (b == HEADER_SECOND)
                    begin
                        rx_phase = PH_BODY;
                        rx_pos = POS_BODY_START;
                        rx_xor ^= b;
                        rx_sum += b;
                    end
                    else if (b != HEADER_FIRST)
                    begin
                        rx_phase = PH_HUNT;
                    end
                end
                PH_BODY:
                begin
                    if (rx_pos >= POS_SAMPLE_FIRST && rx_pos <= POS_SAMPLE_LAST)
                        rx_samples[rx_pos - POS_SAMPLE_FIRST] = b;
                    rx_xor ^= b;
                    rx_sum += b;
                    rx_pos++;
                    if (rx_pos >= POS_XOR)
                    begin
                        rx_pos = POS_XOR;
                        rx_phase = PH_CHECK;
                    end
                end
                default:
                begin
                    total = rx_sum + b;
                    if (rx_pos == POS_XOR)
                    begin
                        if (b != rx_xor)
                        begin
                            emit_status = 1'b1;
                            code = ST_XOR_ERR;
                        end
                        else
                        begin
                            rx_sum = total;
                            rx_pos = POS_SUM;
                        end
                    end
                    else if (total != 8'd0)
                    begin
                        emit_status = 1'b1;
                        code = ST_SUM_ERR;
                    end
                    else
                    begin
                        // good frame: one result per channel
                        span = (window_cfg == 0) ? 1 : int'(window_cfg);
                        if (span > HISTORY_DEPTH)
                            span = HISTORY_DEPTH;
                        for (k = 0; k < CHANNELS; k++)
                        begin
                            sample = {rx_samples[2 * k + 1], rx_samples[2 * k]};
                            win_sums[k] = win_sums[k] - history[write_slot][k] + sample;
                            history[write_slot][k] = sample;
                            res = '0;
                            res.channel = 3'(k);
                            res.latest_sample = sample;
                            res.window_sum = win_sums[k];
                            res.status = ST_OK;
                            res.last = (k == CHANNELS - 1);
                            expected_results.push_back(res);
                        end
                        write_slot++;
                        if (write_slot >= span)
                            write_slot = 0;
                        rx_phase = PH_HUNT;
                    end
                end
            endcase
        end
        if (emit_status)
        begin
            res = '0;
            res.status = code;
            res.last = 1'b1;
            expected_results.push_back(res);
            rx_phase = PH_HUNT;
        end
    endfunction

    function automatic void push_item(logic [7:0] b, logic timeout);
        fsms_in_t item;
        item.rx_byte = b;
        item.timeout_flag = timeout;
        pending_items.push_back(item);
    endfunction

    // appends one byte sequence, returns the number of items that count toward the phase
    function automatic int append_sequence(seq_kind_t kind);
        logic [7:0] frame [FRAME_BYTES];
        logic [7:0] xsum;
        logic [7:0] asum;
        int cut;
        int i;
        int r;
        if (kind == SEQ_RANDOM)
        begin
            r = $urandom_range(0, 19);
            if (r < 11)
                kind = SEQ_GOOD;
            else if (r < 13)
                kind = SEQ_BAD_XOR;
            else if (r < 15)
                kind = SEQ_BAD_SUM;
            else if (r < 17)
                kind = SEQ_TIMEOUT_ANY;
            else if (r == 17)
                kind = SEQ_TIMEOUT_XOR;
            else if (r == 18)
                kind = SEQ_TIMEOUT_SUM;
            else
                kind = SEQ_NOISE;
        end
        if (kind == SEQ_NOISE)
        begin
            cut = $urandom_range(1, 4);
            for (i = 0; i < cut; i++)
            begin
                if (i == 0 && $urandom_range(0, 2) == 0)
                    push_item(HEADER_FIRST, 1'b0);
                else
                    push_item(8'($urandom), $urandom_range(0, 7) == 0);
            end
            return 0;
        end
        frame[0] = HEADER_FIRST;
        frame[1] = HEADER_SECOND;
        xsum = HEADER_FIRST ^ HEADER_SECOND;
        asum = HEADER_FIRST + HEADER_SECOND;
        for (i = 2; i < POS_XOR; i++)
        begin
            if (i >= POS_SAMPLE_FIRST && i <= POS_SAMPLE_LAST && $urandom_range(0, 2) == 0)
                frame[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                frame[i] = 8'($urandom);
            xsum ^= frame[i];
            asum += frame[i];
        end
        asum += xsum;
        frame[POS_XOR] = xsum;
        frame[POS_SUM] = 8'(0 - asum);
        case (kind)
            SEQ_BAD_XOR: frame[POS_XOR] ^= 8'($urandom_range(1, 255));
            SEQ_BAD_SUM: frame[POS_SUM] += 8'($urandom_range(1, 255));
            default: ;
        endcase
        case (kind)
            SEQ_TIMEOUT_ANY: cut = $urandom_range(0, FRAME_BYTES - 1);
            SEQ_TIMEOUT_XOR: cut = POS_XOR;
            SEQ_TIMEOUT_SUM: cut = POS_SUM;
            default: cut = FRAME_BYTES;
        endcase
        // repeated first header byte
        if ($urandom_range(0, 3) == 0)
            push_item(HEADER_FIRST, 1'b0);
        for (i = 0; i < cut; i++)
            push_item(frame[i], 1'b0);
        if (cut < FRAME_BYTES)
        begin
            push_item(8'($urandom), 1'b1);
            return cut + 1;
        end
        return cut;
    endfunction

    function automatic void compare_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                parse_byte(in_data);
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    in_data <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %p", $time, out_data);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("channel", want.channel, out_data.channel);
                    compare_field("latest_sample", want.latest_sample, out_data.latest_sample);
                    compare_field("window_sum", want.window_sum, out_data.window_sum);
                    compare_field("status", want.status, out_data.status);
                    compare_field("last", want.last, out_data.last);
                end
            end
            out_stall <= (holdoff_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            holdoff_left <= 0;
        end
        else if (holdoff_arm && !holdoff_used)
        begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_used <= 1'b1;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int counted;
        int s;
        int c;
        for (s = 0; s < HISTORY_DEPTH; s++)
            for (c = 0; c < CHANNELS; c++)
                history[s][c] = '0;
        for (c = 0; c < CHANNELS; c++)
            win_sums[c] = '0;
        for (s = 0; s < SAMPLE_BYTES; s++)
            rx_samples[s] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        for (phase = 0; phase < PHASES; phase++)
        begin
            // first phase runs on the reset window length
            if (phase != 0)
            begin
                @(posedge clk);
                cfg_valid <= 1'b1;
                cfg_data <= 8'(PHASE_WINDOW[phase]);
                do
                    @(posedge clk);
                while (!cfg_ready);
                cfg_valid <= 1'b0;
                window_cfg = 8'(PHASE_WINDOW[phase]);
            end
            @(negedge clk);
            sender_idle_pct = PHASE_SEND_IDLE[phase];
            recv_stall_pct = PHASE_RECV_STALL[phase];
            if (phase == 0)
            begin
                // timeout while hunting, byte ignored
                push_item(8'hFF, 1'b1);
                push_item(HEADER_FIRST, 1'b1);
                // timeout after first header byte
                push_item(HEADER_FIRST, 1'b0);
                push_item(8'h00, 1'b1);
                // header mismatch
                push_item(HEADER_FIRST, 1'b0);
                push_item(8'h12, 1'b0);
                push_item(HEADER_SECOND, 1'b0);
                // repeated first header byte, then short frame
                push_item(HEADER_FIRST, 1'b0);
                push_item(HEADER_FIRST, 1'b0);
                push_item(HEADER_SECOND, 1'b0);
                push_item(8'h3C, 1'b0);
                push_item(8'hFF, 1'b0);
                push_item(8'h00, 1'b1);
                holdoff_arm = 1'b1;
            end
            counted = append_sequence(PHASE_FIRST_KIND[phase]);
            while (counted < PHASE_ITEMS[phase])
            begin
                counted += append_sequence(SEQ_RANDOM);
                if ($urandom_range(0, 2) == 0)
                    void'(append_sequence(SEQ_NOISE));
            end
            // sender pauses until every result is back
            do
                @(negedge clk);
            while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
